/* hdl/sdag_pkg.sv */
// Shared types and codes for the strided DMA address generator.
`timescale 1ns / 1ps

package sdag_pkg;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int RAM_SIZE_W = 25;
   localparam logic [CSR_ADDR_W-1:0] CSR_RAM_SIZE = 3'd0;
   localparam logic [RAM_SIZE_W-1:0] RAM_SIZE_RESET = 25'd8388608;

   localparam logic [1:0] KIND_TO_LOCAL = 2'd0;
   localparam logic [1:0] KIND_TO_MAIN  = 2'd1;
   localparam logic [1:0] KIND_TICK     = 2'd2;

   localparam logic [2:0] STATUS_IDLE          = 3'd0;
   localparam logic [2:0] STATUS_BYTE          = 3'd1;
   localparam logic [2:0] STATUS_ACCEPTED      = 3'd2;
   localparam logic [2:0] STATUS_RAM_OVERFLOW  = 3'd3;
   localparam logic [2:0] STATUS_SEGMENT_CROSS = 3'd4;
   localparam logic [2:0] STATUS_BUSY_REFUSED  = 3'd5;

   localparam logic [21:0] SEGMENT_SIZE = 22'h1000;

   typedef struct packed {
      logic [1:0]  kind;
      logic [12:0] local_addr_word;
      logic [23:0] main_addr_word;
      logic [31:0] length_word;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [12:0] local_address;
      logic [23:0] main_address;
      logic        toward_main;
      logic        last_byte;
   } rsp_type;

   typedef struct packed {
      logic ram_overflow;
      logic segment_cross;
   } check_type;

endpackage

/* hdl/sdag_start_check.sv */
// Range checks of a start transfer against main memory size and the local segment.
`timescale 1ns / 1ps

module sdag_start_check (
   input  sdag_pkg::req_type   req,
   input  logic [24:0]         ram_size,
   output sdag_pkg::check_type check
);
   import sdag_pkg::*;

   logic [11:0] len;
   logic [12:0] len_p1;
   logic [8:0]  cnt_p1;
   logic [13:0] stride;
   logic [22:0] main_span;
   logic [24:0] main_end;
   logic [21:0] seg_span;
   logic [21:0] seg_end;

   always_comb begin
      len       = {req.length_word[11:3], 3'b111};
      len_p1    = {1'b0, len} + 13'd1;
      cnt_p1    = {1'b0, req.length_word[19:12]} + 9'd1;
      stride    = {1'b0, len_p1} + {2'b00, req.length_word[31:20]};
      main_span = {9'd0, stride} * {14'd0, cnt_p1};
      main_end  = {1'b0, req.main_addr_word[23:3], 3'b000} + {2'b00, main_span};
      seg_span  = len_p1 * cnt_p1;
      seg_end   = seg_span + {10'd0, req.local_addr_word[11:0]};
      check.ram_overflow  = main_end > ram_size;
      check.segment_cross = seg_end > SEGMENT_SIZE;
   end

endmodule

/* hdl/strided_dma_address_generator.sv */
// Top level of the strided DMA address generator.
`timescale 1ns / 1ps

// A start transfer (kind 0 or 1) is checked against ram_size and the 4 KB local
// segment and answered with accepted, ram overflow, segment cross or, while a
// transfer runs, busy refused. Each tick transfer (kind 2) then returns one
// byte address pair; the main address jumps by the skip after every row and
// the final byte carries last_byte. Every request gives exactly one response.
// Throughput is one transfer per cycle while rsp_stall does not hold the output;
// a request goes from request to response through an input register and a response
// register, with the range check (two small multiplies, five adds and two compares) between them.
// ram_size sits at byte address 0 of the register port and resets to 8 MB.

module strided_dma_address_generator (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  sdag_pkg::req_type    req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output sdag_pkg::rsp_type    rsp_data,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [2:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);
   import sdag_pkg::*;

   logic [RAM_SIZE_W-1:0] ram_size_ff;

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic        busy_ff, busy_in;
   logic        direction_ff, direction_in;
   logic [12:0] local_pointer_ff, local_pointer_in;
   logic [23:0] main_pointer_ff, main_pointer_in;
   logic [11:0] bytes_left_ff, bytes_left_in;
   logic [7:0]  rows_left_ff, rows_left_in;
   logic [11:0] row_length_ff, row_length_in;
   logic [11:0] row_skip_ff, row_skip_in;

   logic      advance, take, fire;
   check_type check;
   logic [12:0] start_local;
   logic [23:0] start_main;
   logic [23:0] main_step;

   sdag_start_check u_check (
      .req      (in_data_ff),
      .ram_size (ram_size_ff),
      .check    (check)
   );

   assign pready = 1'b1;
   assign prdata = {{(CSR_DATA_W-RAM_SIZE_W){1'b0}}, ram_size_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         ram_size_ff <= RAM_SIZE_RESET;
      end else if (psel && penable && pwrite && paddr == CSR_RAM_SIZE) begin
         ram_size_ff <= pwdata[RAM_SIZE_W-1:0];
      end
   end

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign take      = req_valid && !req_stall;
   assign fire      = in_valid_ff && advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign in_valid_in  = take || (in_valid_ff && !advance);
   assign rsp_valid_in = fire || (rsp_valid_ff && rsp_stall);

   always_comb begin
      busy_in          = busy_ff;
      direction_in     = direction_ff;
      local_pointer_in = local_pointer_ff;
      main_pointer_in  = main_pointer_ff;
      bytes_left_in    = bytes_left_ff;
      rows_left_in     = rows_left_ff;
      row_length_in    = row_length_ff;
      row_skip_in      = row_skip_ff;
      rsp_data_in      = '0;
      rsp_data_in.status = STATUS_IDLE;
      start_local = {in_data_ff.local_addr_word[12:3], 3'b000};
      start_main  = {in_data_ff.main_addr_word[23:3], 3'b000};
      main_step   = main_pointer_ff + 24'd1;

      case (in_data_ff.kind)
         KIND_TO_LOCAL, KIND_TO_MAIN: begin
            if (busy_ff) begin
               rsp_data_in.status = STATUS_BUSY_REFUSED;
            end else if (check.ram_overflow) begin
               rsp_data_in.status = STATUS_RAM_OVERFLOW;
            end else if (check.segment_cross) begin
               rsp_data_in.status = STATUS_SEGMENT_CROSS;
            end else begin
               busy_in          = 1'b1;
               direction_in     = in_data_ff.kind[0];
               local_pointer_in = start_local;
               main_pointer_in  = start_main;
               row_length_in    = {in_data_ff.length_word[11:3], 3'b111};
               row_skip_in      = in_data_ff.length_word[31:20];
               bytes_left_in    = {in_data_ff.length_word[11:3], 3'b111};
               rows_left_in     = in_data_ff.length_word[19:12];
               rsp_data_in.status        = STATUS_ACCEPTED;
               rsp_data_in.local_address = start_local;
               rsp_data_in.main_address  = start_main;
               rsp_data_in.toward_main   = in_data_ff.kind[0];
            end
         end
         KIND_TICK: begin
            if (busy_ff) begin
               rsp_data_in.status        = STATUS_BYTE;
               rsp_data_in.local_address = local_pointer_ff;
               rsp_data_in.main_address  = main_pointer_ff;
               rsp_data_in.toward_main   = direction_ff;
               rsp_data_in.last_byte     = bytes_left_ff == 12'd0 && rows_left_ff == 8'd0;
               local_pointer_in = local_pointer_ff + 13'd1;
               if (bytes_left_ff != 12'd0) begin
                  main_pointer_in = main_step;
                  bytes_left_in   = bytes_left_ff - 12'd1;
               end else begin
                  main_pointer_in = main_step + {12'd0, row_skip_ff};
                  bytes_left_in   = row_length_ff;
                  if (rows_left_ff != 8'd0) begin
                     rows_left_in = rows_left_ff - 8'd1;
                  end else begin
                     busy_in = 1'b0;
                  end
               end
            end
         end
         default: begin
            rsp_data_in.status = STATUS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         busy_ff          <= 1'b0;
         direction_ff     <= 1'b0;
         local_pointer_ff <= '0;
         main_pointer_ff  <= '0;
         bytes_left_ff    <= '0;
         rows_left_ff     <= '0;
         row_length_ff    <= '0;
         row_skip_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            busy_ff          <= busy_in;
            direction_ff     <= direction_in;
            local_pointer_ff <= local_pointer_in;
            main_pointer_ff  <= main_pointer_in;
            bytes_left_ff    <= bytes_left_in;
            rows_left_ff     <= rows_left_in;
            row_length_ff    <= row_length_in;
            row_skip_ff      <= row_skip_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_data_ff <= req_data;
      end
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the strided DMA address generator.
`timescale 1ns / 1ps

module tb_top;
   import sdag_pkg::*;

   localparam logic [1:0] KIND_UNUSED = 2'd3;

   typedef struct {
      req_type    req;
      bit         fixed;
      logic [2:0] want;
   } vector_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_data;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // predicted block state
   logic                  dma_busy = 1'b0;
   logic                  dma_toward_main = 1'b0;
   logic [12:0]           dma_local_ptr = '0;
   logic [23:0]           dma_main_ptr = '0;
   logic [11:0]           dma_row_bytes_left = '0;
   logic [7:0]            dma_rows_left = '0;
   logic [11:0]           dma_row_len = '0;
   logic [11:0]           dma_row_skip = '0;
   logic [RAM_SIZE_W-1:0] dma_ram_size = RAM_SIZE_RESET;

   rsp_type               addr_pairs_due[$];
   vector_type            vectors[$];
   int unsigned           items_sent = 0;
   int unsigned           req_calm = 0;
   int unsigned           rsp_calm = 0;
   bit                    mismatch_seen = 1'b0;

   strided_dma_address_generator i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always #4 clock = ~clock;

   function automatic int unsigned idle_len(inout int unsigned calm);
      int unsigned r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         calm = $urandom_range(10, 60);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 25);
   endfunction

   function automatic rsp_type next_transfer_rsp(req_type r);
      rsp_type     o;
      logic [31:0] len, cnt, skp, maddr, laddr, main_end, seg_end;
      o = '0;
      if (r.kind == KIND_TO_LOCAL || r.kind == KIND_TO_MAIN) begin
         maddr    = {8'd0, r.main_addr_word & 24'hFFFFF8};
         laddr    = {19'd0, r.local_addr_word & 13'h1FF8};
         len      = {20'd0, r.length_word[11:0] | 12'h007};
         cnt      = {24'd0, r.length_word[19:12]};
         skp      = {20'd0, r.length_word[31:20]};
         main_end = maddr + (len + 32'd1 + skp) * (cnt + 32'd1);
         seg_end  = {20'd0, r.local_addr_word[11:0]} + (len + 32'd1) * (cnt + 32'd1);
         if (dma_busy) begin
            o.status = STATUS_BUSY_REFUSED;
         end else if (main_end > {7'd0, dma_ram_size}) begin
            o.status = STATUS_RAM_OVERFLOW;
         end else if (seg_end > {10'd0, SEGMENT_SIZE}) begin
            o.status = STATUS_SEGMENT_CROSS;
         end else begin
            dma_busy           = 1'b1;
            dma_toward_main    = r.kind[0];
            dma_local_ptr      = laddr[12:0];
            dma_main_ptr       = maddr[23:0];
            dma_row_len        = len[11:0];
            dma_row_skip       = skp[11:0];
            dma_row_bytes_left = len[11:0];
            dma_rows_left      = cnt[7:0];
            o.status           = STATUS_ACCEPTED;
            o.local_address    = laddr[12:0];
            o.main_address     = maddr[23:0];
            o.toward_main      = r.kind[0];
         end
      end else if (r.kind == KIND_TICK && dma_busy) begin
         o.status        = STATUS_BYTE;
         o.local_address = dma_local_ptr;
         o.main_address  = dma_main_ptr;
         o.toward_main   = dma_toward_main;
         o.last_byte     = (dma_row_bytes_left == 0 && dma_rows_left == 0);
         dma_local_ptr   = dma_local_ptr + 13'd1;
         dma_main_ptr    = dma_main_ptr + 24'd1;
         if (dma_row_bytes_left != 0) begin
            dma_row_bytes_left = dma_row_bytes_left - 12'd1;
         end else begin
            dma_main_ptr       = dma_main_ptr + {12'd0, dma_row_skip};
            dma_row_bytes_left = dma_row_len;
            if (dma_rows_left != 0) dma_rows_left = dma_rows_left - 8'd1;
            else dma_busy = 1'b0;
         end
      end
      return o;
   endfunction

   function automatic void add_vector(logic [1:0] k, logic [12:0] l, logic [23:0] m,
                                      logic [31:0] w, bit fixed, logic [2:0] want);
      vector_type v;
      v.req   = {k, l, m, w};
      v.fixed = fixed;
      v.want  = want;
      vectors.push_back(v);
   endfunction

   task automatic send_item(req_type r, bit fixed, logic [2:0] want);
      rsp_type     due;
      int unsigned gap;
      gap = idle_len(req_calm);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      due = next_transfer_rsp(r);
      if (fixed) begin
         due        = '0;
         due.status = want;
      end
      addr_pairs_due.push_back(due);
      items_sent++;
   endtask

   task automatic send_noise();
      req_type r;
      r.kind            = 2'($urandom_range(0, 3));
      r.local_addr_word = 13'($urandom);
      r.main_addr_word  = 24'($urandom);
      r.length_word     = $urandom;
      // near misses: small sizes at random addresses
      if ($urandom_range(0, 1) == 0) r.length_word[19:5] = {8'($urandom_range(0, 7)), 7'd0};
      send_item(r, 1'b0, STATUS_IDLE);
   endtask

   task automatic drain_transfer();
      req_type r;
      while (dma_busy) begin
         if ($urandom_range(0, 19) == 0) begin
            send_noise();
         end else begin
            r.kind            = KIND_TICK;
            r.local_addr_word = 13'($urandom);
            r.main_addr_word  = 24'($urandom);
            r.length_word     = $urandom;
            send_item(r, 1'b0, STATUS_IDLE);
         end
      end
   endtask

   task automatic run_transfer();
      req_type     r;
      logic [11:0] len_m1, skp;
      logic [7:0]  cnt;
      int unsigned total, span, top, lo, m;
      len_m1 = 12'(($urandom_range(0, 99) < 90) ? $urandom_range(0, 31)
                                                 : $urandom_range(0, 127));
      cnt    = 8'(($urandom_range(0, 99) < 90) ? $urandom_range(0, 3)
                                                : $urandom_range(4, 15));
      skp    = 12'($urandom);
      total  = ({20'd0, len_m1 | 12'h007} + 1) * ({24'd0, cnt} + 1);
      span   = ({20'd0, len_m1 | 12'h007} + 1 + {20'd0, skp}) * ({24'd0, cnt} + 1);
      lo     = $urandom_range(0, 4096 - total);
      if (dma_ram_size >= span) begin
         top = dma_ram_size - span;
         if ($urandom_range(0, 3) == 0) m = top - ((top < 64) ? top : $urandom_range(0, 64));
         else m = $urandom_range(0, top);
      end else begin
         m = $urandom;
      end
      r.kind                  = 2'($urandom_range(0, 1));
      r.local_addr_word[12]   = 1'($urandom_range(0, 1));
      r.local_addr_word[11:0] = lo[11:0];
      r.main_addr_word        = m[23:0];
      r.length_word           = {skp, cnt, len_m1};
      send_item(r, 1'b0, STATUS_IDLE);
      drain_transfer();
   endtask

   task automatic csr_access(bit wr, logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= addr;
      pwdata  <= wdata;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic check_ram_size();
      logic [CSR_DATA_W-1:0] rd;
      csr_access(1'b0, CSR_RAM_SIZE, '0, rd);
      if (rd[RAM_SIZE_W-1:0] !== dma_ram_size) begin
         $error("ram_size: expected %0d, got %0d", dma_ram_size, rd[RAM_SIZE_W-1:0]);
         mismatch_seen = 1'b1;
      end
   endtask

   task automatic set_ram_size(logic [RAM_SIZE_W-1:0] v);
      logic [CSR_DATA_W-1:0] rd;
      csr_access(1'b1, CSR_RAM_SIZE, {{(CSR_DATA_W-RAM_SIZE_W){1'b0}}, v}, rd);
      dma_ram_size = v;
      check_ram_size();
   endtask

   initial begin
      int unsigned hold;
      rsp_stall = 1'b0;
      forever begin
         hold = idle_len(rsp_calm);
         repeat (hold) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
         end
         hold = $urandom_range(1, 6);
         repeat (hold) begin
            @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (addr_pairs_due.size() == 0) begin
            $error("transfer with nothing pending: status %0d", rsp_data.status);
            mismatch_seen = 1'b1;
         end else begin
            want = addr_pairs_due.pop_front();
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_data.status);
               mismatch_seen = 1'b1;
            end
            if (rsp_data.local_address !== want.local_address) begin
               $error("local_address: expected %h, got %h", want.local_address,
                      rsp_data.local_address);
               mismatch_seen = 1'b1;
            end
            if (rsp_data.main_address !== want.main_address) begin
               $error("main_address: expected %h, got %h", want.main_address,
                      rsp_data.main_address);
               mismatch_seen = 1'b1;
            end
            if (rsp_data.toward_main !== want.toward_main) begin
               $error("toward_main: expected %b, got %b", want.toward_main,
                      rsp_data.toward_main);
               mismatch_seen = 1'b1;
            end
            if (rsp_data.last_byte !== want.last_byte) begin
               $error("last_byte: expected %b, got %b", want.last_byte, rsp_data.last_byte);
               mismatch_seen = 1'b1;
            end
         end
      end
   end

   initial begin
      #8000000;
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      int unsigned           phase_end;
      logic [RAM_SIZE_W-1:0] ram_choice;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      psel      = 1'b0;
      penable   = 1'b0;
      pwrite    = 1'b0;
      paddr     = '0;
      pwdata    = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      add_vector(KIND_TICK,     13'h0000, 24'h000000, 32'h00000000, 1, STATUS_IDLE);
      add_vector(KIND_UNUSED,   13'h1FFF, 24'hFFFFFF, 32'hFFFFFFFF, 1, STATUS_IDLE);
      add_vector(KIND_TO_LOCAL, 13'h0000, 24'hFFFFFF, 32'h00000000, 1, STATUS_RAM_OVERFLOW);
      add_vector(KIND_TO_MAIN,  13'h1FFF, 24'hFFFFFF, 32'hFFFFFFFF, 1, STATUS_RAM_OVERFLOW);
      add_vector(KIND_TO_LOCAL, 13'h0000, 24'h7FFFFF, 32'h00100000, 1, STATUS_RAM_OVERFLOW);
      add_vector(KIND_TO_LOCAL, 13'h0FF9, 24'h000000, 32'h00000000, 1, STATUS_SEGMENT_CROSS);
      add_vector(KIND_TO_MAIN,  13'h0001, 24'h000000, 32'h00100FFF, 1, STATUS_SEGMENT_CROSS);
      add_vector(KIND_TO_MAIN,  13'h1FF8, 24'h7FFFFF, 32'h00000000, 0, STATUS_IDLE);
      repeat (3) add_vector(KIND_TICK, 13'h0000, 24'h000000, 32'h00000000, 0, STATUS_IDLE);
      add_vector(KIND_TO_LOCAL, 13'h0000, 24'h000000, 32'h00000000, 1, STATUS_BUSY_REFUSED);
      add_vector(KIND_TICK,     13'h1FFF, 24'hFFFFFF, 32'hFFFFFFFF, 0, STATUS_IDLE);
      repeat (4) add_vector(KIND_TICK, 13'h0000, 24'h000000, 32'h00000000, 0, STATUS_IDLE);
      add_vector(KIND_TICK,     13'h0000, 24'h000000, 32'h00000000, 1, STATUS_IDLE);
      add_vector(KIND_TO_LOCAL, 13'h0003, 24'h000001, 32'hFFF01000, 0, STATUS_IDLE);

      check_ram_size();
      foreach (vectors[i]) send_item(vectors[i].req, vectors[i].fixed, vectors[i].want);
      drain_transfer();

      for (int p = 0; p < 6; p++) begin
         if (p > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            while (addr_pairs_due.size() != 0) @(posedge clock);
            case (p)
               1: ram_choice = 25'd16777216;
               2: ram_choice = 25'd0;
               3: ram_choice = 25'($urandom_range(8, 16777216));
               4: ram_choice = 25'($urandom_range(64, 65536));
               default: ram_choice = 25'(32'd16777216 - $urandom_range(0, 4096));
            endcase
            set_ram_size(ram_choice);
         end
         phase_end = items_sent + 30;
         while (items_sent < phase_end) begin
            if ($urandom_range(0, 99) < 70) run_transfer();
            else send_noise();
         end
         drain_transfer();
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (addr_pairs_due.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (!mismatch_seen) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

/* strided_dma_address_generator.f */
hdl/sdag_pkg.sv
hdl/sdag_start_check.sv
hdl/strided_dma_address_generator.sv
verif/tb_top.sv
